// ----- rtl/bssm_pkg.sv -----
// shared constants, types and helpers for the byte stream substring matcher
`default_nettype none

package bssm_pkg;

  localparam int MAX_PATTERN_DEFAULT   = 16;
  localparam int COUNTER_WIDTH_DEFAULT = 32;
  localparam int PATTERN_SLOTS         = 16;
  localparam int CFG_DATA_WIDTH        = 64;
  localparam int CFG_INDEX_WIDTH       = 2;
  localparam int LENGTH_REG_WIDTH      = 5;
  localparam int RESULT_WIDTH          = 32;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] UPPER_FIRST  = 8'h41;
  localparam logic [7:0] UPPER_LAST   = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LEN  = 2'd2,
    REG_CASE_FOLD    = 2'd3
  } reg_index_t;

  // control travelling with the word held between the window and match stages
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic enable);
    logic [7:0] r;
    r = b;
    if (enable && b >= UPPER_FIRST && b <= UPPER_LAST) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bssm_window.sv -----
// input stage: byte window, byte and line counters, stage register control
`default_nettype none

module bssm_window #(
  parameter int MAX_PATTERN   = bssm_pkg::MAX_PATTERN_DEFAULT,
  parameter int COUNTER_WIDTH = bssm_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   byte_valid,
  output logic                                        byte_ready,
  input  wire logic [7:0]                             byte_value,
  input  wire logic                                   last_byte,
  input  wire logic                                   advance,
  output bssm_pkg::stage_ctl_t                        ctl,
  output logic [MAX_PATTERN-1:0][7:0]                 window,
  output logic [$clog2(MAX_PATTERN+1)-1:0]            bytes_seen,
  output logic [COUNTER_WIDTH-1:0]                    line_count,
  output logic [COUNTER_WIDTH-1:0]                    item_position
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] SEEN_MAX = LEN_W'(MAX_PATTERN);

  logic                               accept;
  logic                               clear_pending;
  logic [COUNTER_WIDTH-1:0]           byte_position;
  logic [MAX_PATTERN-1:0][7:0]        window_base;
  logic [MAX_PATTERN-1:0][7:0]        window_next;
  logic [LEN_W-1:0]                   seen_base;
  logic [LEN_W-1:0]                   seen_next;
  logic [COUNTER_WIDTH-1:0]           line_base;
  logic [COUNTER_WIDTH-1:0]           line_next;
  logic [COUNTER_WIDTH-1:0]           position_base;
  logic [COUNTER_WIDTH-1:0]           position_next;

  assign byte_ready = !ctl.valid || advance;
  assign accept     = byte_valid && byte_ready;

  // the previous word ended a file: start this one from reset values
  always_comb begin
    window_base   = clear_pending ? '0 : window;
    seen_base     = clear_pending ? '0 : bytes_seen;
    line_base     = clear_pending ? COUNTER_WIDTH'(1) : line_count;
    position_base = clear_pending ? '0 : byte_position;

    seen_next     = (seen_base < SEEN_MAX) ? seen_base + LEN_W'(1) : seen_base;
    line_next     = (byte_value == bssm_pkg::NEWLINE_BYTE && line_base != '1)
                    ? line_base + COUNTER_WIDTH'(1) : line_base;
    position_next = (position_base != '1) ? position_base + COUNTER_WIDTH'(1)
                    : position_base;
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_shift
    if (i == 0) begin : g_head
      assign window_next[i] = byte_value;
    end else begin : g_tail
      assign window_next[i] = window_base[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl           <= '0;
      clear_pending <= 1'b0;
      window        <= '0;
      bytes_seen    <= '0;
      line_count    <= COUNTER_WIDTH'(1);
      byte_position <= '0;
      item_position <= '0;
    end else begin
      if (accept) begin
        ctl.valid     <= 1'b1;
        ctl.last      <= last_byte;
        clear_pending <= last_byte;
        window        <= window_next;
        bytes_seen    <= seen_next;
        line_count    <= line_next;
        byte_position <= position_next;
        item_position <= position_base;
      end else if (advance) begin
        ctl.valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= SEEN_MAX)
    else $error("byte count passed the pattern size");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0)
    else $error("line count reached zero");
`endif

endmodule

`default_nettype wire

// ----- rtl/bssm_match.sv -----
// match stage: window compare, overlap holdoff, per-line report and result register
`default_nettype none

module bssm_match #(
  parameter int MAX_PATTERN   = bssm_pkg::MAX_PATTERN_DEFAULT,
  parameter int COUNTER_WIDTH = bssm_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire bssm_pkg::stage_ctl_t                          ctl,
  input  wire logic [MAX_PATTERN-1:0][7:0]                   window,
  input  wire logic [$clog2(MAX_PATTERN+1)-1:0]              bytes_seen,
  input  wire logic [COUNTER_WIDTH-1:0]                      line_count,
  input  wire logic [COUNTER_WIDTH-1:0]                      item_position,
  input  wire logic [bssm_pkg::CFG_DATA_WIDTH-1:0]           pattern_low,
  input  wire logic [bssm_pkg::CFG_DATA_WIDTH-1:0]           pattern_high,
  input  wire logic [bssm_pkg::LENGTH_REG_WIDTH-1:0]         pattern_length,
  input  wire logic                                          case_fold,
  output logic                                               advance,
  output logic                                               match_valid,
  input  wire logic                                          match_ready,
  output logic [bssm_pkg::RESULT_WIDTH-1:0]                  match_line,
  output logic [bssm_pkg::RESULT_WIDTH-1:0]                  match_offset
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int SLOTS = bssm_pkg::PATTERN_SLOTS;
  localparam logic [bssm_pkg::LENGTH_REG_WIDTH-1:0] LEN_LIMIT =
    bssm_pkg::LENGTH_REG_WIDTH'(MAX_PATTERN);

  logic [SLOTS-1:0][7:0]       pattern;
  logic [LEN_W-1:0]            len;
  logic [MAX_PATTERN-1:0]      lane_ok;
  logic                        hit;
  logic                        report;
  logic [LEN_W-1:0]            holdoff;
  logic [LEN_W-1:0]            holdoff_next;
  logic [COUNTER_WIDTH-1:0]    last_reported_line;
  logic [COUNTER_WIDTH-1:0]    last_reported_next;
  logic [COUNTER_WIDTH-1:0]    len_minus_one;
  logic [COUNTER_WIDTH-1:0]    start;
  logic [63:0]                 line_wide;
  logic [63:0]                 start_wide;

  for (genvar k = 0; k < SLOTS; k++) begin : g_pattern
    if (k < 8) begin : g_low
      assign pattern[k] = pattern_low[8*k +: 8];
    end else begin : g_high
      assign pattern[k] = pattern_high[8*(k-8) +: 8];
    end
  end

  assign len = (pattern_length > LEN_LIMIT) ? LEN_W'(MAX_PATTERN) : LEN_W'(pattern_length);

  // window entry j (newest first) lines up with pattern byte len-1-j
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
    logic [LEN_W-1:0] slot;
    assign slot = len - LEN_W'(1) - LEN_W'(j);
    assign lane_ok[j] = (LEN_W'(j) >= len) ||
      (bssm_pkg::fold_byte(window[j], case_fold) ==
       bssm_pkg::fold_byte(pattern[4'(slot)], case_fold));
  end

  assign hit     = (len != '0) && (bytes_seen >= len) && (&lane_ok);
  assign advance = ctl.valid && (!match_valid || match_ready);

  always_comb begin
    holdoff_next       = holdoff;
    last_reported_next = last_reported_line;
    report             = 1'b0;
    if (holdoff != '0) begin
      holdoff_next = holdoff - LEN_W'(1);
    end else if (hit) begin
      holdoff_next = len - LEN_W'(1);
      if (line_count != last_reported_line) begin
        report             = 1'b1;
        last_reported_next = line_count;
      end
    end
    if (ctl.last) begin
      holdoff_next       = '0;
      last_reported_next = '0;
    end
  end

  assign len_minus_one = COUNTER_WIDTH'(len) - COUNTER_WIDTH'(1);
  assign start = (item_position >= len_minus_one) ? item_position - len_minus_one : '0;
  assign line_wide  = 64'(line_count);
  assign start_wide = 64'(start);

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff            <= '0;
      last_reported_line <= '0;
      match_valid        <= 1'b0;
    end else begin
      if (advance) begin
        holdoff            <= holdoff_next;
        last_reported_line <= last_reported_next;
      end
      if (advance && report) begin
        match_valid <= 1'b1;
      end else if (match_ready) begin
        match_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && report) begin
      match_line   <= line_wide[bssm_pkg::RESULT_WIDTH-1:0];
      match_offset <= start_wide[bssm_pkg::RESULT_WIDTH-1:0];
    end
  end

`ifndef SYNTHESIS
  a_holdoff_blocks: assert property (@(posedge clk) disable iff (rst)
    (holdoff != '0) |-> !report)
    else $error("match reported inside a previous match");

  a_holdoff_bounded: assert property (@(posedge clk) disable iff (rst)
    holdoff < LEN_W'(MAX_PATTERN))
    else $error("holdoff longer than the pattern");

  a_report_records_line: assert property (@(posedge clk) disable iff (rst)
    (advance && report && !ctl.last) |=> (last_reported_line == $past(line_count)))
    else $error("reported line not recorded");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (advance && report) |=> match_valid)
    else $error("result register not loaded");
`endif

endmodule

`default_nettype wire

// ----- rtl/byte_stream_substring_match.sv -----
// top level: configuration registers and the two-stage byte matcher
`default_nettype none

// Searches a file, one byte per word, for a pattern of up to MAX_PATTERN bytes
// (optionally ignoring ASCII letter case) and reports the line number and start
// offset of the first non-overlapping match on each line. Lines count from 1,
// offsets from 0, both saturating at COUNTER_WIDTH bits; a word with last_byte set
// ends the file and the next word starts a fresh one with the same configuration.
// One byte is taken per cycle while byte_ready is high: the byte enters the window
// and counter register stage, then a parallel compare across the whole window
// decides the match and loads the result register, so a result is registered
// behind the window stage that held its last byte. A waiting result stalls input
// only once the stage behind it is full.
// Configuration is written through cfg_write/cfg_index/cfg_data while no bytes are
// in flight.
module byte_stream_substring_match #(
  parameter int MAX_PATTERN   = bssm_pkg::MAX_PATTERN_DEFAULT,
  parameter int COUNTER_WIDTH = bssm_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [bssm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [bssm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  wire logic                                   byte_valid,
  output logic                                        byte_ready,
  input  wire logic [7:0]                             byte_value,
  input  wire logic                                   last_byte,
  output logic                                        match_valid,
  input  wire logic                                   match_ready,
  output logic [bssm_pkg::RESULT_WIDTH-1:0]           match_line,
  output logic [bssm_pkg::RESULT_WIDTH-1:0]           match_offset
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [bssm_pkg::CFG_DATA_WIDTH-1:0]    pattern_low;
  logic [bssm_pkg::CFG_DATA_WIDTH-1:0]    pattern_high;
  logic [bssm_pkg::LENGTH_REG_WIDTH-1:0]  pattern_length;
  logic                                   case_fold;

  bssm_pkg::stage_ctl_t                   ctl;
  logic [MAX_PATTERN-1:0][7:0]            window;
  logic [LEN_W-1:0]                       bytes_seen;
  logic [COUNTER_WIDTH-1:0]               line_count;
  logic [COUNTER_WIDTH-1:0]               item_position;
  logic                                   advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      case_fold      <= 1'b0;
    end else if (cfg_write) begin
      case (bssm_pkg::reg_index_t'(cfg_index))
        bssm_pkg::REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        bssm_pkg::REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        bssm_pkg::REG_PATTERN_LEN:
          pattern_length <= cfg_data[bssm_pkg::LENGTH_REG_WIDTH-1:0];
        bssm_pkg::REG_CASE_FOLD:    case_fold      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bssm_window #(
    .MAX_PATTERN   (MAX_PATTERN),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .byte_value    (byte_value),
    .last_byte     (last_byte),
    .advance       (advance),
    .ctl           (ctl),
    .window        (window),
    .bytes_seen    (bytes_seen),
    .line_count    (line_count),
    .item_position (item_position)
  );

  bssm_match #(
    .MAX_PATTERN   (MAX_PATTERN),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_match (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .window         (window),
    .bytes_seen     (bytes_seen),
    .line_count     (line_count),
    .item_position  (item_position),
    .pattern_low    (pattern_low),
    .pattern_high   (pattern_high),
    .pattern_length (pattern_length),
    .case_fold      (case_fold),
    .advance        (advance),
    .match_valid    (match_valid),
    .match_ready    (match_ready),
    .match_line     (match_line),
    .match_offset   (match_offset)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_byte_stream_substring_match.sv -----
// self-checking testbench for byte_stream_substring_match: predictor scoreboard and random traffic
module tb_byte_stream_substring_match;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];
  typedef struct packed {
    logic [31:0] line;
    logic [31:0] offset;
  } hit_t;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam int WINDOW = 16;
  localparam int ITEM_GOAL = 1500;
  localparam int CALM_AFTER = 1300;
  localparam int LONG_HOLD = 250;
  localparam int SETTLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [7:0] POOL[6] = '{"a", "A", "b", "B", "z", 8'h0A};

  // tracks pattern registers and stream state, and holds the matches still to come out
  class match_predictor;
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0] pat_len;
    logic fold_en;
    logic [7:0] window[WINDOW];
    int unsigned filled;
    int unsigned holdoff;
    logic [31:0] line_no;
    logic [31:0] next_pos;
    logic [31:0] reported_line;
    hit_t pending_matches[$];
    int mismatches;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      pat_len = '0;
      fold_en = 1'b0;
      mismatches = 0;
      restart_file();
    endfunction

    function void restart_file();
      foreach (window[i]) window[i] = '0;
      filled = 0;
      holdoff = 0;
      line_no = 32'd1;
      next_pos = '0;
      reported_line = '0;
    endfunction

    function void set_register(bssm_pkg::reg_index_t idx, logic [63:0] v);
      case (idx)
        bssm_pkg::REG_PATTERN_LOW: pat_lo = v;
        bssm_pkg::REG_PATTERN_HIGH: pat_hi = v;
        bssm_pkg::REG_PATTERN_LEN: pat_len = v[4:0];
        bssm_pkg::REG_CASE_FOLD: fold_en = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned active_len();
      return (pat_len > WINDOW) ? WINDOW : pat_len;
    endfunction

    function logic [7:0] pattern_at(int unsigned k);
      return (k < 8) ? pat_lo[k*8 +: 8] : pat_hi[(k-8)*8 +: 8];
    endfunction

    function logic [7:0] folded(logic [7:0] b);
      return (fold_en && b >= "A" && b <= "Z") ? b + 8'h20 : b;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int unsigned n;
      logic [31:0] start_at;
      logic [31:0] span;
      bit hit;
      n = active_len();
      start_at = next_pos;
      for (int i = WINDOW - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = b;
      if (filled < WINDOW) filled++;
      if (b == bssm_pkg::NEWLINE_BYTE && line_no != COUNT_MAX) line_no++;
      if (next_pos != COUNT_MAX) next_pos++;
      if (holdoff > 0) begin
        holdoff--;
      end else if (n > 0 && filled >= n) begin
        hit = 1'b1;
        for (int k = 0; k < n; k++)
          if (folded(window[n - 1 - k]) != folded(pattern_at(k))) hit = 1'b0;
        if (hit) begin
          // a match blocks overlap even when its line was already reported
          holdoff = n - 1;
          span = n - 1;
          if (line_no != reported_line) begin
            pending_matches.insert(pending_matches.size(),
              hit_t'{line: line_no, offset: (start_at >= span) ? start_at - span : 32'd0});
            reported_line = line_no;
          end
        end
      end
      if (last) restart_file();
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_match(logic [31:0] line_v, logic [31:0] offset_v);
      hit_t want;
      if (pending_matches.size() == 0) begin
        report($sformatf("match with none expected: line %0d offset %0d", line_v, offset_v));
        return;
      end
      want = pending_matches.pop_front();
      if (line_v !== want.line)
        report($sformatf("match_line %0d, expected %0d", line_v, want.line));
      if (offset_v !== want.offset)
        report($sformatf("match_offset %0d, expected %0d", offset_v, want.offset));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [bssm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [bssm_pkg::CFG_DATA_WIDTH-1:0] cfg_data;
  logic byte_valid;
  logic byte_ready;
  logic [7:0] byte_value;
  logic last_byte;
  logic match_valid;
  logic match_ready;
  logic [bssm_pkg::RESULT_WIDTH-1:0] match_line;
  logic [bssm_pkg::RESULT_WIDTH-1:0] match_offset;

  match_predictor sb;
  int items_sent = 0;
  int long_hold = 0;
  bit calm = 1'b0;

  byte_stream_substring_match dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_value(byte_value),
    .last_byte(last_byte),
    .match_valid(match_valid),
    .match_ready(match_ready),
    .match_line(match_line),
    .match_offset(match_offset)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && match_valid && match_ready) sb.check_match(match_line, match_offset);
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    match_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold > 0) begin
        stall_left = long_hold;
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      match_ready <= (stall_left == 0);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] flip_letter(logic [7:0] b);
    logic [7:0] low;
    low = b | 8'h20;
    return (low >= "a" && low <= "z") ? b ^ 8'h20 : b;
  endfunction

  function automatic logic [7:0] vary_case(logic [7:0] b, bit allow);
    return (allow && $urandom_range(0, 1) == 1) ? flip_letter(b) : b;
  endfunction

  function automatic logic [63:0] pattern_word(bit letters);
    logic [63:0] w;
    for (int j = 0; j < 8; j++)
      w[j*8 +: 8] = letters ? POOL[$urandom_range(0, 5)] : 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic logic [4:0] pick_len();
    case ($urandom_range(0, 19))
      0: return 5'd0;
      1: return 5'($urandom_range(17, 31));
      2: return 5'd16;
      3, 4, 5: return 5'($urandom_range(7, 15));
      default: return 5'($urandom_range(1, 6));
    endcase
  endfunction

  // file body built from pattern copies, partial prefixes, newlines and noise
  function automatic byte_q_t make_file();
    byte_q_t q;
    int unsigned n;
    int unsigned target;
    int unsigned cut;
    bit flip_some;
    n = sb.active_len();
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
    flip_some = sb.fold_en ? 1'b1 : ($urandom_range(0, 3) == 0);
    while (q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: for (int k = 0; k < n; k++)
          q.insert(q.size(), vary_case(sb.pattern_at(k), flip_some));
        3: if (n > 1) begin
          cut = $urandom_range(1, n - 1);
          for (int k = 0; k < cut; k++)
            q.insert(q.size(), vary_case(sb.pattern_at(k), flip_some));
        end
        4: q.insert(q.size(), bssm_pkg::NEWLINE_BYTE);
        5: q.insert(q.size(), 8'($urandom_range(0, 255)));
        default: q.insert(q.size(), n > 0 ? sb.pattern_at($urandom_range(0, n - 1))
                                          : POOL[$urandom_range(0, 5)]);
      endcase
    end
    return q;
  endfunction

  // valid stays up across words and files apart from random gaps while not calm; settle lowers it
  task automatic send_bytes(input byte_q_t q, input bit close_file);
    bit tail;
    for (int i = 0; i < q.size(); i++) begin
      tail = close_file && (i == q.size() - 1);
      if (!calm && $urandom_range(0, 7) == 0) begin
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      byte_valid <= 1'b1;
      byte_value <= q[i];
      last_byte <= tail;
      do @(posedge clk); while (byte_ready !== 1'b1);
      sb.take_byte(q[i], tail);
      items_sent++;
    end
  endtask

  task automatic settle();
    int guard = 0;
    byte_valid <= 1'b0;
    while (sb.pending_matches.size() != 0 && guard < SETTLE_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    foreach (sb.pending_matches[i])
      sb.report($sformatf("missing match: line %0d offset %0d",
                          sb.pending_matches[i].line, sb.pending_matches[i].offset));
    sb.pending_matches.delete();
    // a last word may still be in flight without producing a match
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bssm_pkg::reg_index_t idx, input logic [63:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_register(idx, v);
  endtask

  task automatic configure(input logic [3:0] mask, input logic [63:0] lo, input logic [63:0] hi,
                           input logic [63:0] len_w, input logic [63:0] fold_w);
    if (mask[bssm_pkg::REG_PATTERN_LOW]) write_reg(bssm_pkg::REG_PATTERN_LOW, lo);
    if (mask[bssm_pkg::REG_PATTERN_HIGH]) write_reg(bssm_pkg::REG_PATTERN_HIGH, hi);
    if (mask[bssm_pkg::REG_PATTERN_LEN]) write_reg(bssm_pkg::REG_PATTERN_LEN, len_w);
    if (mask[bssm_pkg::REG_CASE_FOLD]) write_reg(bssm_pkg::REG_CASE_FOLD, fold_w);
    cfg_write <= 1'b0;
  endtask

  task automatic run_random_phase(input bit opening);
    logic [3:0] mask;
    logic [63:0] len_w;
    logic [63:0] fold_w;
    bit letters;
    int files;
    letters = ($urandom_range(0, 3) != 0);
    mask = opening ? 4'hF : 4'($urandom_range(1, 15));
    len_w = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 1) len_w[63:5] = '0;
    len_w[4:0] = pick_len();
    fold_w = {$urandom, $urandom};
    configure(mask, pattern_word(letters), pattern_word(letters), len_w, fold_w);
    files = $urandom_range(1, 4);
    // sometimes the phase stops mid-file so the next settings land mid-stream
    for (int f = 0; f < files; f++)
      send_bytes(make_file(), (f < files - 1) || ($urandom_range(0, 3) != 0));
    settle();
  endtask

  initial begin
    byte_q_t q;
    bit opening;
    sb = new();
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= bssm_pkg::REG_PATTERN_LOW;
    cfg_data <= '0;
    byte_valid <= 1'b0;
    byte_value <= '0;
    last_byte <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pattern straight out of reset
    q = '{8'h00, 8'h00, 8'hFF};
    send_bytes(q, 1'b1);
    settle();

    // "aab" folded: partial restart, then a second hit on the same line
    configure(4'hF, 64'hA5C3_0F00_FF62_6161, 64'h0, 64'd3, 64'd1);
    q = '{"a", "A", "a", "b", "a", "a", "b"};
    send_bytes(q, 1'b1);
    settle();

    // pattern ending in a newline, no folding
    configure(4'((1 << bssm_pkg::REG_PATTERN_LOW) | (1 << bssm_pkg::REG_PATTERN_LEN) |
                 (1 << bssm_pkg::REG_CASE_FOLD)),
              64'h0000_0000_0000_0A78, 64'h0, 64'd2, 64'hFFFF_FFFF_FFFF_FFFE);
    q = '{"X", 8'h0A, "x", 8'h0A};
    send_bytes(q, 1'b1);
    settle();

    // overlong length with full window, match ends on the file's last word
    configure(4'hF, 64'hFF00_7F80_0A41_61FF, 64'h00FF_0102_0304_5A06,
              64'hFFFF_FFFF_FFFF_FFFF, 64'h1);
    q.delete();
    for (int k = 0; k < WINDOW; k++) q.insert(q.size(), flip_letter(sb.pattern_at(k)));
    send_bytes(q, 1'b1);
    settle();

    // every newline is a match on a new line; hold results off so the block backs up
    configure(4'((1 << bssm_pkg::REG_PATTERN_LOW) | (1 << bssm_pkg::REG_PATTERN_LEN)),
              64'h0A, 64'h0, 64'd1, 64'h0);
    q.delete();
    for (int k = 0; k < 48; k++)
      q.insert(q.size(), ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : bssm_pkg::NEWLINE_BYTE);
    long_hold = LONG_HOLD;
    send_bytes(q, 1'b1);
    settle();

    opening = 1'b1;
    while (items_sent < ITEM_GOAL) begin
      calm = (items_sent >= CALM_AFTER);
      run_random_phase(opening);
      opening = 1'b0;
    end

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bssm_pkg.sv
rtl/bssm_window.sv
rtl/bssm_match.sv
rtl/byte_stream_substring_match.sv
tb/sv/tb_byte_stream_substring_match.sv
